@@ hw/rtl/trhc_pkg.sv @@
// Shared widths, codes and item types for the two-relay hysteresis controller.
`timescale 1ns / 1ps

package trhc_pkg;

    // Field and register widths.
    localparam int TIME_BITS     = 32;
    localparam int LIGHT_BITS    = 12;
    localparam int TEMP_BITS     = 12;
    localparam int FAN_HYST_BITS = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (TIME_BITS > LIGHT_BITS) ? TIME_BITS : LIGHT_BITS;

    // Register values after reset.
    localparam int DARK_THR_RST   = 1000;
    localparam int DARK_HYST_RST  = 200;
    localparam int MOTION_WIN_RST = 60000;
    localparam int MIN_DWELL_RST  = 2000;
    localparam int FAN_HYST_RST   = 16;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CYCLE = 2'd2
    } t_cmd;

    // Relay channel modes.
    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DARK_THR   = 3'd0,
        CFG_DARK_HYST  = 3'd1,
        CFG_MOTION_WIN = 3'd2,
        CFG_MIN_DWELL  = 3'd3,
        CFG_FAN_HYST   = 3'd4
    } t_cfg_idx;

    // One input item as held in the input register.
    typedef struct packed {
        logic [1:0]                  command;
        logic                        channel;
        logic [1:0]                  new_mode;
        logic [TIME_BITS-1:0]        now_ms;
        logic [TIME_BITS-1:0]        last_motion_ms;
        logic                        alarm_disarmed;
        logic [LIGHT_BITS-1:0]       light_raw;
        logic                        light_valid;
        logic signed [TEMP_BITS-1:0] temp_fixed;
        logic                        temp_valid;
        logic signed [TEMP_BITS-1:0] fan_threshold;
    } t_item;

endpackage

@@ hw/rtl/trhc_item_if.sv @@
// Input item channel of the two-relay hysteresis controller.
`timescale 1ns / 1ps

interface trhc_item_if
    import trhc_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic                        channel;
    logic [1:0]                  new_mode;
    logic [TIME_BITS-1:0]        now_ms;
    logic [TIME_BITS-1:0]        last_motion_ms;
    logic                        alarm_disarmed;
    logic [LIGHT_BITS-1:0]       light_raw;
    logic                        light_valid;
    logic signed [TEMP_BITS-1:0] temp_fixed;
    logic                        temp_valid;
    logic signed [TEMP_BITS-1:0] fan_threshold;

    modport source (
        output valid, command, channel, new_mode, now_ms, last_motion_ms,
               alarm_disarmed, light_raw, light_valid, temp_fixed, temp_valid,
               fan_threshold,
        input  ready
    );

    modport sink (
        input  valid, command, channel, new_mode, now_ms, last_motion_ms,
               alarm_disarmed, light_raw, light_valid, temp_fixed, temp_valid,
               fan_threshold,
        output ready
    );
endinterface

@@ hw/rtl/trhc_result_if.sv @@
// Result item channel of the two-relay hysteresis controller.
`timescale 1ns / 1ps

interface trhc_result_if
    import trhc_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       lamp_on;
    logic       fan_on;
    logic [1:0] lamp_mode_out;
    logic [1:0] fan_mode_out;
    logic       is_dark;

    modport source (
        output valid, lamp_on, fan_on, lamp_mode_out, fan_mode_out, is_dark,
        input  ready
    );

    modport sink (
        input  valid, lamp_on, fan_on, lamp_mode_out, fan_mode_out, is_dark,
        output ready
    );
endinterface

@@ hw/rtl/two_relay_hysteresis_controller.sv @@
// Top level of the two-relay hysteresis controller: lamp and fan relay control.
//
//   Channel    Direction  Handshake          Carries
//   i_item     in         valid / ready      command, mode and sensor readings
//   o_result   out        valid / ready      relay states, modes, dark latch
//   i_cfg_*    in         write enable only  threshold, window and dwell registers
//
// Each item waits in the input register; the rule evaluation between that register
// and the state registers is combinational: one item per clock unless o_result stalls.
// The relay, mode and dark-latch state registers double as the result register.
// A result waiting on o_result stalls the evaluation, while one more item may still
// enter the input register. Reset is synchronous, active low, with no clearing pass.
`timescale 1ns / 1ps

module two_relay_hysteresis_controller
    import trhc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    trhc_item_if.sink                i_item,
    trhc_result_if.source            o_result,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers.
    logic [LIGHT_BITS-1:0]    r_dark_thr;
    logic [LIGHT_BITS-1:0]    r_dark_hyst;
    logic [TIME_BITS-1:0]     r_motion_win;
    logic [TIME_BITS-1:0]     r_min_dwell;
    logic [FAN_HYST_BITS-1:0] r_fan_hyst;

    // Input register and result valid.
    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;

    // Controller state.
    logic                 r_dark;
    logic                 r_relay [2];
    logic [TIME_BITS-1:0] r_last  [2];
    logic [1:0]           r_mode  [2];

    logic                 n_dark;
    logic                 n_relay [2];
    logic [TIME_BITS-1:0] n_last  [2];
    logic [1:0]           n_mode  [2];

    logic                 w_take;
    logic                 w_adv;
    logic                 w_eval;
    logic                 w_want  [2];
    logic                 w_tgt   [2];
    logic                 w_en    [2];
    logic [TIME_BITS-1:0] w_sw_dt [2];
    logic [TIME_BITS-1:0] w_motion_dt;
    logic [LIGHT_BITS:0]  w_clear_lvl;
    logic signed [TEMP_BITS+1:0] w_temp;
    logic signed [TEMP_BITS+1:0] w_fan_thr;
    logic signed [TEMP_BITS+1:0] w_fan_low;

    // Handshake: the input slot drains when the result slot is free or being taken.
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_take       = i_item.valid && i_item.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_thr   <= LIGHT_BITS'(DARK_THR_RST);
            r_dark_hyst  <= LIGHT_BITS'(DARK_HYST_RST);
            r_motion_win <= TIME_BITS'(MOTION_WIN_RST);
            r_min_dwell  <= TIME_BITS'(MIN_DWELL_RST);
            r_fan_hyst   <= FAN_HYST_BITS'(FAN_HYST_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DARK_THR:   r_dark_thr   <= i_cfg_data[LIGHT_BITS-1:0];
                CFG_DARK_HYST:  r_dark_hyst  <= i_cfg_data[LIGHT_BITS-1:0];
                CFG_MOTION_WIN: r_motion_win <= i_cfg_data[TIME_BITS-1:0];
                CFG_MIN_DWELL:  r_min_dwell  <= i_cfg_data[TIME_BITS-1:0];
                CFG_FAN_HYST:   r_fan_hyst   <= i_cfg_data[FAN_HYST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input payload capture.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.command        <= i_item.command;
            r_in.channel        <= i_item.channel;
            r_in.new_mode       <= i_item.new_mode;
            r_in.now_ms         <= i_item.now_ms;
            r_in.last_motion_ms <= i_item.last_motion_ms;
            r_in.alarm_disarmed <= i_item.alarm_disarmed;
            r_in.light_raw      <= i_item.light_raw;
            r_in.light_valid    <= i_item.light_valid;
            r_in.temp_fixed     <= i_item.temp_fixed;
            r_in.temp_valid     <= i_item.temp_valid;
            r_in.fan_threshold  <= i_item.fan_threshold;
        end
    end

    assign w_eval = (r_in.command == CMD_EVAL);

    // Dark latch with hysteresis on the light level.
    assign w_clear_lvl = {1'b0, r_dark_thr} + {1'b0, r_dark_hyst};

    always_comb begin
        n_dark = r_dark;
        if (w_eval && r_in.light_valid) begin
            if (!n_dark && (r_in.light_raw < r_dark_thr)) begin
                n_dark = 1'b1;
            end
            if (n_dark && ({1'b0, r_in.light_raw} > w_clear_lvl)) begin
                n_dark = 1'b0;
            end
        end
    end

    // Age of the last motion stamp, modulo the time width.
    assign w_motion_dt = r_in.now_ms - r_in.last_motion_ms;

    // Fan thresholds widened so that the margin cannot overflow.
    assign w_temp    = (TEMP_BITS+2)'(r_in.temp_fixed);
    assign w_fan_thr = (TEMP_BITS+2)'(r_in.fan_threshold);
    assign w_fan_low = w_fan_thr - $signed({{(TEMP_BITS+2-FAN_HYST_BITS){1'b0}}, r_fan_hyst});

    // Lamp request: dark, recent motion and alarm disarmed.
    // Fan request: on above the threshold, off below threshold minus margin or with no reading.
    always_comb begin
        w_want[0] = n_dark && (r_in.last_motion_ms != '0) &&
                    (w_motion_dt < r_motion_win) && r_in.alarm_disarmed;
        w_want[1] = 1'b0;
        if (r_in.temp_valid) begin
            w_want[1] = r_relay[1];
            if (w_temp > w_fan_thr) begin
                w_want[1] = 1'b1;
            end
            if (w_temp < w_fan_low) begin
                w_want[1] = 1'b0;
            end
        end
    end

    // Relay switching with minimum dwell time, and mode commands.
    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            n_relay[ch] = r_relay[ch];
            n_last[ch]  = r_last[ch];
            n_mode[ch]  = r_mode[ch];
            w_en[ch]    = 1'b1;
            w_tgt[ch]   = 1'b0;
            case (r_mode[ch])
                MODE_AUTO: w_tgt[ch] = w_want[ch];
                MODE_ON:   w_tgt[ch] = 1'b1;
                MODE_OFF:  w_tgt[ch] = 1'b0;
                default:   w_en[ch]  = 1'b0;
            endcase
            w_sw_dt[ch] = r_in.now_ms - r_last[ch];

            if (w_eval) begin
                if (w_en[ch] && (w_tgt[ch] != r_relay[ch]) &&
                    ((r_last[ch] == '0) || (w_sw_dt[ch] >= r_min_dwell))) begin
                    n_relay[ch] = w_tgt[ch];
                    n_last[ch]  = r_in.now_ms;
                end
            end else if (r_in.channel == 1'(ch)) begin
                if (r_in.command == CMD_SET) begin
                    if ((r_in.new_mode == MODE_AUTO) || (r_in.new_mode == MODE_ON) ||
                        (r_in.new_mode == MODE_OFF)) begin
                        n_mode[ch] = r_in.new_mode;
                        n_last[ch] = '0;
                    end
                end else if (r_in.command == CMD_CYCLE) begin
                    case (r_mode[ch])
                        MODE_AUTO: n_mode[ch] = MODE_ON;
                        MODE_ON:   n_mode[ch] = MODE_OFF;
                        default:   n_mode[ch] = MODE_AUTO;
                    endcase
                    n_last[ch] = '0;
                end
            end
        end
    end

    // State update, which is also the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                r_relay[ch] <= 1'b0;
                r_last[ch]  <= '0;
                r_mode[ch]  <= MODE_AUTO;
            end
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_dark      <= n_dark;
                for (int ch = 0; ch < 2; ch++) begin
                    r_relay[ch] <= n_relay[ch];
                    r_last[ch]  <= n_last[ch];
                    r_mode[ch]  <= n_mode[ch];
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result outputs.
    assign o_result.valid         = r_out_valid;
    assign o_result.lamp_on       = r_relay[0];
    assign o_result.fan_on        = r_relay[1];
    assign o_result.lamp_mode_out = r_mode[0];
    assign o_result.fan_mode_out  = r_mode[1];
    assign o_result.is_dark       = r_dark;

`ifndef NO_ASSERTIONS
    // The lamp relay moves only on an evaluated item, and records its switch time.
    a_lamp_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relay[0] != $past(r_relay[0])) |->
            ($past(w_adv && w_eval) && (r_last[0] == $past(r_in.now_ms))))
        else $error("lamp relay changed outside an evaluate step");

    // The fan relay moves only on an evaluated item, and records its switch time.
    a_fan_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relay[1] != $past(r_relay[1])) |->
            ($past(w_adv && w_eval) && (r_last[1] == $past(r_in.now_ms))))
        else $error("fan relay changed outside an evaluate step");

    // A mode change clears that channel's switch time.
    a_mode_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode[0] != $past(r_mode[0])) || (r_mode[1] != $past(r_mode[1]))) |->
            (((r_mode[0] == $past(r_mode[0])) || (r_last[0] == '0)) &&
             ((r_mode[1] == $past(r_mode[1])) || (r_last[1] == '0))))
        else $error("mode changed without clearing switch time");

    // A held item is not dropped from the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("input item lost while stalled");
`endif

endmodule

@@ test/tb_two_relay_hysteresis_controller.sv @@
// Self-checking testbench for the two-relay hysteresis controller against a status model.
`timescale 1ns / 1ps

module tb_two_relay_hysteresis_controller
    import trhc_pkg::*;
;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 120;

    // Codes outside the package enums that the block must tolerate, and the channel selects.
    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam logic [1:0] MODE_INVALID = 2'd3;
    localparam logic       CH_LAMP      = 1'b0;
    localparam logic       CH_FAN       = 1'b1;

    // One result item as the block reports it.
    typedef struct packed {
        logic       lamp_on;
        logic       fan_on;
        logic [1:0] lamp_mode_out;
        logic [1:0] fan_mode_out;
        logic       is_dark;
    } t_status;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    trhc_item_if   item_if ();
    trhc_result_if result_if ();

    two_relay_hysteresis_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Register copies used by the status model.
    logic [LIGHT_BITS-1:0]    reg_dark_thr    = LIGHT_BITS'(DARK_THR_RST);
    logic [LIGHT_BITS-1:0]    reg_dark_hyst   = LIGHT_BITS'(DARK_HYST_RST);
    logic [TIME_BITS-1:0]     reg_motion_win  = TIME_BITS'(MOTION_WIN_RST);
    logic [TIME_BITS-1:0]     reg_min_dwell   = TIME_BITS'(MIN_DWELL_RST);
    logic [FAN_HYST_BITS-1:0] reg_fan_hyst    = FAN_HYST_BITS'(FAN_HYST_RST);

    // Controller state as the model sees it, reset values included.
    logic                 mdl_dark = 1'b0;
    logic                 mdl_relay [2] = '{1'b0, 1'b0};
    logic [TIME_BITS-1:0] mdl_last_switch [2] = '{'0, '0};
    t_mode                mdl_mode [2] = '{MODE_AUTO, MODE_AUTO};

    t_status status_expected_q [$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      rx_hold_req = 0;
    bit      idle_in     = 1'b1;
    bit      idle_out    = 1'b1;

    // Running scenario values for the random traffic.
    logic [TIME_BITS-1:0] sim_now       = '0;
    logic [TIME_BITS-1:0] motion_stamp  = '0;
    int                   pot_threshold = 320;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Applies one item to the model state and returns the status it leaves behind.
    function automatic t_status compute_relay_status(input t_item it);
        t_status              st;
        logic [LIGHT_BITS:0]  clear_level;
        logic [TIME_BITS-1:0] age;
        logic                 want [2];
        logic                 target;
        int                   temp_val;
        int                   thr_val;
        int                   sel;
        t_mode                next_mode;

        sel = int'(it.channel);
        case (it.command)
            CMD_EVAL: begin
                // Dark latch with hysteresis, only on a valid light reading.
                if (it.light_valid) begin
                    clear_level = {1'b0, reg_dark_thr} + {1'b0, reg_dark_hyst};
                    if (!mdl_dark && it.light_raw < reg_dark_thr) mdl_dark = 1'b1;
                    if (mdl_dark && {1'b0, it.light_raw} > clear_level) mdl_dark = 1'b0;
                end
                age = it.now_ms - it.last_motion_ms;
                want[0] = mdl_dark && (it.last_motion_ms != '0) && (age < reg_motion_win)
                          && it.alarm_disarmed;
                // Fan hysteresis band below the threshold; no reading means off.
                want[1] = mdl_relay[1];
                if (it.temp_valid) begin
                    temp_val = int'(it.temp_fixed);
                    thr_val  = int'(it.fan_threshold);
                    if (temp_val > thr_val) want[1] = 1'b1;
                    if (temp_val < thr_val - int'(reg_fan_hyst)) want[1] = 1'b0;
                end else begin
                    want[1] = 1'b0;
                end
                // Each relay follows its mode, held off by the minimum dwell.
                for (int ch = 0; ch < 2; ch++) begin
                    case (mdl_mode[ch])
                        MODE_AUTO: target = want[ch];
                        MODE_ON:   target = 1'b1;
                        default:   target = 1'b0;
                    endcase
                    age = it.now_ms - mdl_last_switch[ch];
                    if (target != mdl_relay[ch] &&
                        (mdl_last_switch[ch] == '0 || age >= reg_min_dwell)) begin
                        mdl_last_switch[ch] = it.now_ms;
                        mdl_relay[ch]       = target;
                    end
                end
            end
            CMD_SET: begin
                if (it.new_mode != MODE_INVALID) begin
                    mdl_mode[sel]        = t_mode'(it.new_mode);
                    mdl_last_switch[sel] = '0;
                end
            end
            CMD_CYCLE: begin
                case (mdl_mode[sel])
                    MODE_AUTO: next_mode = MODE_ON;
                    MODE_ON:   next_mode = MODE_OFF;
                    default:   next_mode = MODE_AUTO;
                endcase
                mdl_mode[sel]        = next_mode;
                mdl_last_switch[sel] = '0;
            end
            default: begin
            end
        endcase

        st.lamp_on       = mdl_relay[0];
        st.fan_on        = mdl_relay[1];
        st.lamp_mode_out = mdl_mode[0];
        st.fan_mode_out  = mdl_mode[1];
        st.is_dark       = mdl_dark;
        return st;
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_item make_eval(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] motion,
                                        input logic alarm, input int light,
                                        input logic light_ok, input int temp,
                                        input logic temp_ok, input int thr);
        t_item it;

        it                = '0;
        it.command        = CMD_EVAL;
        it.now_ms         = now;
        it.last_motion_ms = motion;
        it.alarm_disarmed = alarm;
        it.light_raw      = light[LIGHT_BITS-1:0];
        it.light_valid    = light_ok;
        it.temp_fixed     = temp[TEMP_BITS-1:0];
        it.temp_valid     = temp_ok;
        it.fan_threshold  = thr[TEMP_BITS-1:0];
        return it;
    endfunction

    function automatic t_item make_mode(input logic [1:0] cmd, input logic ch,
                                        input logic [1:0] mode);
        t_item it;

        it          = '0;
        it.command  = cmd;
        it.channel  = ch;
        it.new_mode = mode;
        return it;
    endfunction

    // Mostly plausible sensor sequences with advancing time, some mode
    // commands, and a share of fully random items.
    function automatic t_item rand_item();
        t_item it;
        int    sel;
        int    lvl;
        int    temp_val;
        int    span;

        it.command        = 2'($urandom_range(0, 3));
        it.channel        = 1'($urandom_range(0, 1));
        it.new_mode       = 2'($urandom_range(0, 3));
        it.now_ms         = $urandom;
        it.last_motion_ms = $urandom;
        it.alarm_disarmed = 1'($urandom_range(0, 1));
        it.light_raw      = LIGHT_BITS'($urandom_range(0, 4095));
        it.light_valid    = 1'($urandom_range(0, 1));
        it.temp_fixed     = TEMP_BITS'($urandom_range(0, 4095));
        it.temp_valid     = 1'($urandom_range(0, 1));
        it.fan_threshold  = TEMP_BITS'($urandom_range(0, 4095));

        sel = $urandom_range(0, 99);
        if (sel < 8) return it;
        if (sel < 20) begin
            it.command = ($urandom_range(0, 1) != 0) ? CMD_SET : CMD_CYCLE;
            return it;
        end

        it.command = CMD_EVAL;
        sim_now   += $urandom_range(0, 1500);
        it.now_ms  = ($urandom_range(0, 24) == 0) ? '0 : sim_now;

        // Motion stamps are mostly recent; zero means no motion seen.
        if ($urandom_range(0, 3) == 0) motion_stamp = sim_now;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            it.last_motion_ms = '0;
        end else if (sel > 2) begin
            it.last_motion_ms = motion_stamp;
        end
        it.alarm_disarmed = ($urandom_range(0, 4) != 0);

        // Light levels around the threshold and its clear level.
        if ($urandom_range(0, 3) != 0) begin
            lvl = int'(reg_dark_thr) + int'($urandom_range(0, int'(reg_dark_hyst) + 600))
                  - 300;
            lvl = clamp_int(lvl, 0, 4095);
            it.light_raw = lvl[LIGHT_BITS-1:0];
        end
        it.light_valid = ($urandom_range(0, 9) != 0);

        // Temperatures around a slowly moving fan threshold.
        if ($urandom_range(0, 29) == 0) pot_threshold = int'($urandom_range(0, 4095)) - 2048;
        it.fan_threshold = pot_threshold[TEMP_BITS-1:0];
        if ($urandom_range(0, 4) != 0) begin
            span     = int'(reg_fan_hyst) + 20;
            temp_val = pot_threshold + int'($urandom_range(0, 2 * span)) - span;
            temp_val = clamp_int(temp_val, -2048, 2047);
            it.temp_fixed = temp_val[TEMP_BITS-1:0];
        end
        it.temp_valid = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // Offers one item, after a random gap when idle_in is set; called and left at a falling edge.
    task automatic send_item(input t_item it);
        int gap;

        gap = idle_in ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.command        <= it.command;
        item_if.channel        <= it.channel;
        item_if.new_mode       <= it.new_mode;
        item_if.now_ms         <= it.now_ms;
        item_if.last_motion_ms <= it.last_motion_ms;
        item_if.alarm_disarmed <= it.alarm_disarmed;
        item_if.light_raw      <= it.light_raw;
        item_if.light_valid    <= it.light_valid;
        item_if.temp_fixed     <= it.temp_fixed;
        item_if.temp_valid     <= it.temp_valid;
        item_if.fan_threshold  <= it.fan_threshold;
        item_if.valid          <= 1'b1;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Stops offering items and lets every outstanding result arrive.
    task automatic wait_for_results();
        item_if.valid <= 1'b0;
        while (status_expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_DARK_THR:   reg_dark_thr   = value[LIGHT_BITS-1:0];
            CFG_DARK_HYST:  reg_dark_hyst  = value[LIGHT_BITS-1:0];
            CFG_MOTION_WIN: reg_motion_win = value[TIME_BITS-1:0];
            CFG_MIN_DWELL:  reg_min_dwell  = value[TIME_BITS-1:0];
            CFG_FAN_HYST:   reg_fan_hyst   = value[FAN_HYST_BITS-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_all_regs(input logic [CFG_DATA_BITS-1:0] thr,
                                input logic [CFG_DATA_BITS-1:0] hyst,
                                input logic [CFG_DATA_BITS-1:0] win,
                                input logic [CFG_DATA_BITS-1:0] dwell,
                                input logic [CFG_DATA_BITS-1:0] fan_hyst);
        wait_for_results();
        write_reg(CFG_DARK_THR, thr);
        write_reg(CFG_DARK_HYST, hyst);
        write_reg(CFG_MOTION_WIN, win);
        write_reg(CFG_MIN_DWELL, dwell);
        write_reg(CFG_FAN_HYST, fan_hyst);
    endtask

    task automatic run_random(input int count);
        idle_in  = ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
        repeat (count) send_item(rand_item());
    endtask

    // Set and cycle on both channels, an invalid mode on the lamp and an unknown command on the fan.
    task automatic test_mode_commands();
        send_item(make_eval('0, '0, 1'b0, 0, 1'b0, 0, 1'b0, 0));
        send_item(make_mode(CMD_SET, CH_LAMP, MODE_ON));
        send_item(make_mode(CMD_SET, CH_FAN, MODE_OFF));
        send_item(make_mode(CMD_SET, CH_LAMP, MODE_INVALID));
        send_item(make_eval(32'd100, '0, 1'b0, 0, 1'b0, 0, 1'b0, 0));
        send_item(make_mode(CMD_CYCLE, CH_LAMP, MODE_AUTO));
        send_item(make_mode(CMD_CYCLE, CH_LAMP, MODE_AUTO));
        send_item(make_mode(CMD_CYCLE, CH_FAN, MODE_AUTO));
        send_item(make_mode(CMD_CYCLE, CH_FAN, MODE_AUTO));
        send_item(make_mode(CMD_UNKNOWN, CH_FAN, MODE_OFF));
        send_item(make_mode(CMD_SET, CH_FAN, MODE_AUTO));
    endtask

    // Dark latch edges, motion window across the time wrap, dwell and time zero.
    task automatic test_dark_latch_and_lamp();
        send_item(make_eval(32'h0000_0100, 32'hFFFF_FF00, 1'b1, 4095, 1'b1, 0, 1'b0, 0));
        send_item(make_eval(32'h0000_0180, 32'hFFFF_FF00, 1'b1, 0, 1'b1, 0, 1'b0, 0));
        send_item(make_eval(32'h0000_1000, 32'hFFFF_FF00, 1'b1, 1200, 1'b1, 0, 1'b0, 0));
        send_item(make_eval(32'h0000_2000, '0, 1'b1, 4095, 1'b0, 0, 1'b0, 0));
        send_item(make_eval(32'h0000_2100, 32'h0000_2000, 1'b1, 1201, 1'b1, 0, 1'b0, 0));
        send_item(make_eval(32'h0000_2200, 32'h0000_2000, 1'b0, 999, 1'b1, 0, 1'b0, 0));
        send_item(make_eval('0, 32'hFFFF_FFFF, 1'b1, 0, 1'b1, 0, 1'b0, 0));
        send_item(make_eval(32'd5, '0, 1'b1, 0, 1'b1, 0, 1'b0, 0));
    endtask

    // Fan band edges, extreme temperatures and a missing reading.
    task automatic test_fan_hysteresis();
        send_item(make_eval(32'h0001_0000, '0, 1'b0, 0, 1'b0, 2047, 1'b1, -2048));
        send_item(make_eval(32'h0001_0001, '0, 1'b0, 0, 1'b0, -2048, 1'b1, 2047));
        send_item(make_eval(32'h0002_0000, '0, 1'b0, 0, 1'b0, 100, 1'b1, 100));
        send_item(make_eval(32'h0003_0000, '0, 1'b0, 0, 1'b0, 83, 1'b1, 100));
        send_item(make_eval(32'h0004_0000, '0, 1'b0, 0, 1'b0, 84, 1'b1, 100));
        send_item(make_eval(32'h0005_0000, '0, 1'b0, 0, 1'b0, 2047, 1'b0, -2048));
    endtask

    // Register extremes, random settings, then back to the reset values.
    task automatic test_config_settings();
        set_all_regs('0, '0, '0, '0, '0);
        run_random(60);
        set_all_regs(4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1023);
        run_random(60);
        repeat (2) begin
            set_all_regs($urandom_range(0, 4095), $urandom_range(0, 1023),
                         $urandom_range(0, 200000), $urandom_range(0, 5000),
                         $urandom_range(0, 1023));
            run_random(60);
        end
        set_all_regs(DARK_THR_RST, DARK_HYST_RST, MOTION_WIN_RST, MIN_DWELL_RST,
                     FAN_HYST_RST);
        run_random(60);
    endtask

    // Long random stretch starting just below the time wrap.
    task automatic test_random_traffic();
        sim_now = 32'hFFFF_8000;
        repeat (4) run_random(50);
    endtask

    // The sink holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        wait_for_results();
        idle_in     = 1'b0;
        rx_hold_req = LONG_HOLD;
        repeat (24) send_item(rand_item());
        wait_for_results();
    endtask

    // Result sink with random stalls and an occasional long hold-off.
    initial begin : result_sink
        int stall;

        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                result_if.ready <= 1'b0;
                repeat (rx_hold_req) @(negedge i_clk);
                rx_hold_req = 0;
            end
            stall = idle_out ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (result_if.valid !== 1'b1);
        end
    end

    function automatic void check_field(input string name, input logic [1:0] expected,
                                        input logic [1:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    // Checks each accepted result, then records the expectation of each accepted item.
    always @(posedge i_clk) begin : status_monitor
        t_status exp_status;
        t_item   seen;

        if (i_rst_n) begin
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                if (status_expected_q.size() == 0) begin
                    $error("result item with no expected status pending");
                    fail_count++;
                end else begin
                    exp_status = status_expected_q.pop_front();
                    check_field("lamp_on", exp_status.lamp_on, result_if.lamp_on);
                    check_field("fan_on", exp_status.fan_on, result_if.fan_on);
                    check_field("lamp_mode_out", exp_status.lamp_mode_out,
                                result_if.lamp_mode_out);
                    check_field("fan_mode_out", exp_status.fan_mode_out,
                                result_if.fan_mode_out);
                    check_field("is_dark", exp_status.is_dark, result_if.is_dark);
                end
            end
            if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
                seen.command        = item_if.command;
                seen.channel        = item_if.channel;
                seen.new_mode       = item_if.new_mode;
                seen.now_ms         = item_if.now_ms;
                seen.last_motion_ms = item_if.last_motion_ms;
                seen.alarm_disarmed = item_if.alarm_disarmed;
                seen.light_raw      = item_if.light_raw;
                seen.light_valid    = item_if.light_valid;
                seen.temp_fixed     = item_if.temp_fixed;
                seen.temp_valid     = item_if.temp_valid;
                seen.fan_threshold  = item_if.fan_threshold;
                status_expected_q.push_back(compute_relay_status(seen));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_data               = '0;
        item_if.valid          = 1'b0;
        item_if.command        = '0;
        item_if.channel        = 1'b0;
        item_if.new_mode       = '0;
        item_if.now_ms         = '0;
        item_if.last_motion_ms = '0;
        item_if.alarm_disarmed = 1'b0;
        item_if.light_raw      = '0;
        item_if.light_valid    = 1'b0;
        item_if.temp_fixed     = '0;
        item_if.temp_valid     = 1'b0;
        item_if.fan_threshold  = '0;
        result_if.ready        = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_mode_commands();
        test_dark_latch_and_lamp();
        test_fan_hysteresis();
        test_backpressure();
        test_config_settings();
        test_random_traffic();
        test_backpressure();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ two_relay_hysteresis_controller.f @@
hw/rtl/trhc_pkg.sv
hw/rtl/trhc_item_if.sv
hw/rtl/trhc_result_if.sv
hw/rtl/two_relay_hysteresis_controller.sv
test/tb_two_relay_hysteresis_controller.sv
